// ===== rtl/lap_pkg.sv =====
// Shared types, constants and helpers of the 3x3 Laplacian edge filter.
package lap_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned PixelBits = 8;

  localparam int unsigned AddrBits  = $clog2(MaxWidth);
  localparam int unsigned DimBits   = 11;
  localparam int unsigned EdgeBits  = 12;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned LineBits  = 2 * PixelBits;

  typedef logic [PixelBits-1:0]      pixel_t;
  typedef logic signed [EdgeBits-1:0] edge_t;
  typedef logic [DimBits-1:0]        dim_t;
  typedef logic [CfgIdxBits-1:0]     cfg_idx_t;

  localparam cfg_idx_t RegImageWidth  = cfg_idx_t'(0);
  localparam cfg_idx_t RegImageHeight = cfg_idx_t'(1);

  // Result beat as held in the output queue.
  typedef struct packed {
    edge_t edge_value;
    logic  frame_last;
  } result_t;

  // A zero dimension acts as one, an oversized one as the maximum.
  function automatic dim_t clamp_dim(input dim_t value, input dim_t limit);
    dim_t res;
    if (value == '0) begin
      res = dim_t'(1);
    end else if (value > limit) begin
      res = limit;
    end else begin
      res = value;
    end
    return res;
  endfunction

endpackage

// ===== rtl/lap_if.sv =====
// Stream interfaces of the Laplacian filter: pixel input, edge output, register writes.
interface lap_pix_if;
  import lap_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_value;
  logic   is_tail;
  modport source (output valid, pixel_value, is_tail, input ready);
  modport sink   (input valid, pixel_value, is_tail, output ready);
endinterface

interface lap_edge_if;
  import lap_pkg::*;
  logic  valid;
  logic  ready;
  edge_t edge_value;
  logic  frame_last;
  modport source (output valid, edge_value, frame_last, input ready);
  modport sink   (input valid, edge_value, frame_last, output ready);
endinterface

interface lap_cfg_if;
  import lap_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  dim_t     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lap_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/laplacian_3x3_filter_core.sv =====
// Top level of the streaming 3x3 8-neighbour Laplacian edge filter.
//
//  Port     | Direction | Beat carries
//  ---------+-----------+----------------------------------------------
//  pix_i    | sink      | pixel_value (8 bit grey), is_tail (flush)
//  edge_o   | source    | edge_value (12 bit signed), frame_last
//  cfg_i    | sink      | index (0 width, 1 height), data (11 bit)
//
// One pixel beat is accepted per clock while pix_i.ready is high; a result
// is computed from the stage 1 registers and written into the result queue.
// The single line memory, read and written once per pixel, sets the rate.
// After reset the geometry is 1024 x 1024 and no clearing pass is needed.
// A three-entry result queue absorbs output stalls; pix_i.ready drops only
// when the queue plus the result in flight would overflow it.
module laplacian_3x3_filter_core (
  input  logic clk_i,
  input  logic rst_ni,
  lap_pix_if.sink    pix_i,
  lap_edge_if.source edge_o,
  lap_cfg_if.sink    cfg_i
);
  import lap_pkg::*;

  localparam int unsigned QDepth = 3;
  localparam logic [1:0]  QLast  = 2'(QDepth - 1);

  // ---------------------------------------------------------------------
  // Configuration registers. Any write to a known register restarts the
  // frame position and clears the window.
  // ---------------------------------------------------------------------
  dim_t width_q, height_q;
  logic cfg_hit;

  assign cfg_i.ready = 1'b1;
  assign cfg_hit = cfg_i.valid &&
                   (cfg_i.index == RegImageWidth || cfg_i.index == RegImageHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dim_t'(MaxWidth);
      height_q <= dim_t'(MaxHeight);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegImageWidth) begin
        width_q <= clamp_dim(cfg_i.data, dim_t'(MaxWidth));
      end else if (cfg_i.index == RegImageHeight) begin
        height_q <= clamp_dim(cfg_i.data, dim_t'(MaxHeight));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: accept a pixel, advance the raster position and issue the
  // line memory read for its column.
  // ---------------------------------------------------------------------
  logic [AddrBits-1:0] col_q, col_d;
  dim_t                row_q, row_d;
  logic                in_fire;
  logic                res0, last0;
  pixel_t              pix0;
  logic [DimBits:0]    height_p1;
  logic [DimBits:0]    col_p1;

  // Stage 1 registers.
  logic                s1_valid_q, s1_res_q, s1_last_q;
  logic [AddrBits-1:0] s1_col_q;
  dim_t                s1_row_q;
  pixel_t              s1_low_q;
  logic                fwd_q;
  logic [LineBits-1:0] fwd_data_q;

  // Output queue.
  result_t    q_mem_q [QDepth];
  logic [1:0] q_rd_q, q_wr_q, q_cnt_q;
  logic       q_push, q_pop;

  assign height_p1 = {1'b0, height_q} + (DimBits+1)'(1);
  assign col_p1    = (DimBits+1)'(col_q) + (DimBits+1)'(1);

  // Accept while the queue can take this result and the one now in flight.
  assign pix_i.ready = ({1'b0, q_cnt_q} + 3'(s1_valid_q && s1_res_q)) <= 3'(QDepth - 1);
  assign in_fire     = pix_i.valid && pix_i.ready;

  always_comb begin
    pix0  = (pix_i.is_tail || row_q >= height_q) ? '0 : pix_i.pixel_value;
    res0  = (col_q != '0 && row_q != '0) || (col_q == '0 && row_q >= dim_t'(2));
    last0 = (col_q == '0) && ({1'b0, row_q} == height_p1);
    col_d = col_q;
    row_d = row_q;
    if (last0) begin
      col_d = '0;
      row_d = '0;
    end else if (col_p1 == {1'b0, width_q}) begin
      col_d = '0;
      row_d = row_q + dim_t'(1);
    end else begin
      col_d = col_q + AddrBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Line memory: each entry holds the upper and middle row pixels of one
  // column. Stage 1 writes back the shifted pair at the same column.
  // ---------------------------------------------------------------------
  logic [LineBits-1:0] ram_rdata, ram_wdata;
  pixel_t              up1, mid1;
  logic [LineBits-1:0] line1;

  assign line1     = fwd_q ? fwd_data_q : ram_rdata;
  assign up1       = line1[LineBits-1:PixelBits];
  assign mid1      = line1[PixelBits-1:0];
  assign ram_wdata = {mid1, s1_low_q};

  lap_ram #(
    .Width(LineBits),
    .Depth(MaxWidth)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i(ram_wdata),
    .re_i   (in_fire),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  // When stage 0 reads the column that stage 1 is writing in the same cycle
  // (every pixel of a one-pixel-wide image, and the first pixel right after
  // the final pixel of a frame), the memory returns stale data; the fresh
  // pair is kept aside and used in place of the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      s1_res_q   <= in_fire && res0;
      s1_last_q  <= in_fire && last0;
      fwd_q      <= in_fire && s1_valid_q && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_low_q   <= pix0;
      fwd_data_q <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: assemble the 3x3 window, mask the image border and compute
  // eight times the centre minus the neighbours.
  // ---------------------------------------------------------------------
  pixel_t win_q [6];   // [row*2 + col], col 0 older, col 1 newer
  pixel_t a [3][3];
  edge_t  center_w, neigh_w, edge1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a[k][0] = win_q[k*2];
      a[k][1] = win_q[k*2+1];
    end
    a[0][2] = up1;
    a[1][2] = mid1;
    a[2][2] = s1_low_q;
    if (s1_col_q != '0) begin
      // Centre is one column back in the current row pair.
      if (s1_col_q == AddrBits'(1)) begin
        for (int k = 0; k < 3; k++) a[k][0] = '0;
      end
      if (s1_row_q == dim_t'(1)) begin
        for (int j = 0; j < 3; j++) a[0][j] = '0;
      end
      if (s1_row_q >= height_q) begin
        for (int j = 0; j < 3; j++) a[2][j] = '0;
      end
    end else begin
      // Start of a row: the centre is the last pixel two rows up.
      for (int k = 0; k < 3; k++) a[k][2] = '0;
      if (width_q < dim_t'(2)) begin
        for (int k = 0; k < 3; k++) a[k][0] = '0;
      end
      if (s1_row_q < dim_t'(3)) begin
        for (int j = 0; j < 3; j++) a[0][j] = '0;
      end
      if ({1'b0, s1_row_q} >= height_p1) begin
        for (int j = 0; j < 3; j++) a[2][j] = '0;
      end
    end

    center_w = edge_t'({1'b0, a[1][1], 3'b000});
    neigh_w  = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i != 1 || j != 1) begin
          neigh_w = neigh_w + edge_t'({1'b0, a[i][j]});
        end
      end
    end
    edge1 = center_w - neigh_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) win_q[k] <= '0;
    end else if (cfg_hit || (s1_valid_q && s1_last_q)) begin
      for (int k = 0; k < 6; k++) win_q[k] <= '0;
    end else if (s1_valid_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= up1;
      win_q[2] <= win_q[3];
      win_q[3] <= mid1;
      win_q[4] <= win_q[5];
      win_q[5] <= s1_low_q;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue toward edge_o.
  // ---------------------------------------------------------------------
  assign q_push = s1_valid_q && s1_res_q;
  assign q_pop  = edge_o.valid && edge_o.ready;

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      q_mem_q[q_wr_q] <= '{edge_value: edge1, frame_last: s1_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_rd_q  <= '0;
      q_wr_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (q_push) begin
        q_wr_q <= (q_wr_q == QLast) ? 2'd0 : q_wr_q + 2'd1;
      end
      if (q_pop) begin
        q_rd_q <= (q_rd_q == QLast) ? 2'd0 : q_rd_q + 2'd1;
      end
      case ({q_push, q_pop})
        2'b10:   q_cnt_q <= q_cnt_q + 2'd1;
        2'b01:   q_cnt_q <= q_cnt_q - 2'd1;
        default: q_cnt_q <= q_cnt_q;
      endcase
    end
  end

  assign edge_o.valid      = (q_cnt_q != 2'd0);
  assign edge_o.edge_value = q_mem_q[q_rd_q].edge_value;
  assign edge_o.frame_last = q_mem_q[q_rd_q].frame_last;

`ifndef NO_ASSERTIONS
  // The result queue never receives a beat when it is full.
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_cnt_q != 2'(QDepth)))
    else $error("result queue overflow");

  // Same-column forwarding only arises for a one-pixel-wide image or for
  // the first column of a frame that directly follows the previous one.
  a_fwd_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (width_q == dim_t'(1) || s1_col_q == '0))
    else $error("line memory forwarding at an unexpected column");

  // The column position always stays inside the configured row.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < {1'b0, width_q}))
    else $error("column position beyond image width");
`endif

endmodule

// ===== tb/tb_laplacian_3x3_filter_core.sv =====
// Self-checking testbench of the 3x3 Laplacian edge filter: directed rows, then random frames.
`timescale 1ns / 100ps

module tb_laplacian_3x3_filter_core;
  import lap_pkg::*;

  localparam int ClkHalf       = 5;
  localparam int ResetCycles   = 6;
  // Settling time after the last owed result, for beats still in the pipeline.
  localparam int SettleCycles  = 6;
  localparam int HoldOffCycles = 300;
  localparam int RandomBeats   = 950;
  localparam int DirCount      = 23;
  // Longest stretch of a frame that is cut short.
  localparam int BrokenCap     = 200;

  // Register indexes that decode to nothing; a write there must not disturb a frame.
  localparam cfg_idx_t RegSpare2 = cfg_idx_t'(2);
  localparam cfg_idx_t RegSpare3 = cfg_idx_t'(3);

  typedef enum logic [1:0] {RowPixel, RowReg} row_kind_e;
  typedef enum logic [1:0] {CheckPredict, CheckNone, CheckTyped} row_check_e;

  // One row of the directed stimulus. Register rows use reg_index and reg_data,
  // pixel rows use value and tail; edge_value and frame_last hold a result
  // written out by hand where the row is marked CheckTyped.
  typedef struct packed {
    row_kind_e  kind;
    row_check_e check;
    cfg_idx_t   reg_index;
    dim_t       reg_data;
    pixel_t     value;
    logic       tail;
    edge_t      edge_value;
    logic       frame_last;
  } stim_row_t;

  localparam stim_row_t DirectedRows [DirCount] = '{
    // Reset geometry is 1024 x 1024; the first row of a frame gives nothing.
    '{RowPixel, CheckNone,    RegImageWidth,  11'd0,    8'd255, 1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckNone,    RegImageWidth,  11'd0,    8'd0,   1'b1, 12'sd0, 1'b0},
    // Zero dimensions act as one; these writes also drop the partial frame above.
    '{RowReg,   CheckNone,    RegImageWidth,  11'd0,    8'd0,   1'b0, 12'sd0, 1'b0},
    '{RowReg,   CheckNone,    RegImageHeight, 11'd0,    8'd0,   1'b0, 12'sd0, 1'b0},
    // A 1 x 1 frame of full white: the only result is eight times 255.
    '{RowPixel, CheckNone,    RegImageWidth,  11'd0,    8'd255, 1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckNone,    RegImageWidth,  11'd0,    8'd170, 1'b1, 12'sd0, 1'b0},
    '{RowPixel, CheckTyped,   RegImageWidth,  11'd0,    8'd0,   1'b1, 12'sd2040, 1'b1},
    // A 3 x 3 frame, white with a black center.
    '{RowReg,   CheckNone,    RegImageWidth,  11'd3,    8'd0,   1'b0, 12'sd0, 1'b0},
    '{RowReg,   CheckNone,    RegImageHeight, 11'd3,    8'd0,   1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd255, 1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd255, 1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd255, 1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd255, 1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd0,   1'b0, 12'sd0, 1'b0},
    // An unused register index in the middle of the frame is ignored.
    '{RowReg,   CheckNone,    RegSpare3,      11'd2047, 8'd0,   1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd255, 1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd255, 1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd255, 1'b0, 12'sd0, 1'b0},
    // The last pixel completes the window around the black center.
    '{RowPixel, CheckTyped,   RegImageWidth,  11'd0,    8'd255, 1'b0, -12'sd2040, 1'b0},
    // Flush: a plain pixel below the image still counts as zero.
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd0,   1'b1, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd200, 1'b0, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd0,   1'b1, 12'sd0, 1'b0},
    '{RowPixel, CheckPredict, RegImageWidth,  11'd0,    8'd0,   1'b1, 12'sd0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lap_pix_if  pix_bus ();
  lap_edge_if edge_bus ();
  lap_cfg_if  cfg_bus ();

  laplacian_3x3_filter_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_bus),
    .edge_o (edge_bus),
    .cfg_i  (cfg_bus)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Predictor state: frame geometry, the two stored rows, the two older window
  // columns and the position of the next incoming pixel.
  int     geo_width;
  int     geo_height;
  pixel_t top_line [MaxWidth];
  pixel_t mid_line [MaxWidth];
  int     window_taps [6];
  int     col_pos;
  int     row_pos;

  // Edge values still owed by the block, oldest first.
  result_t pending_edges [$];

  int mismatch_count = 0;
  int pixel_beats    = 0;

  // Idle shaping shared between the stimulus and the result sink.
  bit src_burst    = 1'b0;
  bit sink_eager   = 1'b0;
  bit hold_request = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Frame dimension: small most of the time, with 0, 1 and 2 well represented.
  function automatic dim_t pick_dim(input int limit);
    case ($urandom_range(0, 9))
      0: return dim_t'(0);
      1: return dim_t'(1);
      2: return dim_t'(2);
      default: return dim_t'($urandom_range(1, limit));
    endcase
  endfunction

  function automatic void restart_window();
    int k;
    for (k = 0; k < 6; k++) window_taps[k] = 0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advances the filter by one pixel beat. Returns 1 and fills res when the
  // beat completes the window of a delayed center pixel.
  function automatic bit laplace_step(input pixel_t value, input logic tail,
                                      output result_t res);
    int r, c, crow, ccol, sum, i, j;
    int up, mid, low;
    int a [3][3];
    bit has_res;
    bit last;
    r = row_pos;
    c = col_pos;
    low = (tail || r >= geo_height) ? 0 : int'(value);
    up  = int'(top_line[c]);
    mid = int'(mid_line[c]);
    for (i = 0; i < 3; i++) begin
      a[i][0] = window_taps[2 * i];
      a[i][1] = window_taps[2 * i + 1];
      a[i][2] = 0;
    end
    has_res = 1'b0;
    crow = 0;
    ccol = 0;
    if (c >= 1) begin
      if (r >= 1) begin
        // Center sits one row up and one column left of the new pixel.
        has_res = 1'b1;
        crow = r - 1;
        ccol = c - 1;
        a[0][2] = up;
        a[1][2] = mid;
        a[2][2] = low;
        if (c < 2) for (i = 0; i < 3; i++) a[i][0] = 0;
        if (r < 2) for (j = 0; j < 3; j++) a[0][j] = 0;
        if (r >= geo_height) for (j = 0; j < 3; j++) a[2][j] = 0;
      end
    end else if (r >= 2) begin
      // Start of a row: the pending center is the last column two rows up,
      // and its right-hand column lies outside the image.
      has_res = 1'b1;
      crow = r - 2;
      ccol = geo_width - 1;
      if (geo_width < 2) for (i = 0; i < 3; i++) a[i][0] = 0;
      if (r < 3) for (j = 0; j < 3; j++) a[0][j] = 0;
      if (r - 1 >= geo_height) for (j = 0; j < 3; j++) a[2][j] = 0;
    end

    window_taps[0] = window_taps[1];
    window_taps[1] = up;
    window_taps[2] = window_taps[3];
    window_taps[3] = mid;
    window_taps[4] = window_taps[5];
    window_taps[5] = low;
    top_line[c] = pixel_t'(mid);
    mid_line[c] = pixel_t'(low);

    c++;
    if (c >= geo_width) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;

    res = '0;
    if (has_res) begin
      sum = 8 * a[1][1];
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          if (i != 1 || j != 1) sum -= a[i][j];
        end
      end
      last = (crow == geo_height - 1) && (ccol == geo_width - 1);
      res.edge_value = edge_t'(sum);
      res.frame_last = last;
      // After the final result the position returns to the frame start.
      if (last) restart_window();
    end
    return has_res;
  endfunction

  // Stops offering pixels and waits for every owed result, then lets the
  // pipeline settle, since trailing beats may still be in flight.
  task automatic drain_results();
    pix_bus.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle. Width and height writes
  // restart the frame position in the predictor; spare indexes do nothing.
  task automatic write_reg(input cfg_idx_t idx, input dim_t data);
    drain_results();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    if (idx == RegImageWidth || idx == RegImageHeight) begin
      int dim;
      int limit;
      limit = (idx == RegImageWidth) ? MaxWidth : MaxHeight;
      dim = (data == '0) ? 1 : (int'(data) > limit) ? limit : int'(data);
      if (idx == RegImageWidth) geo_width = dim;
      else geo_height = dim;
      restart_window();
    end
  endtask

  // Offers one pixel beat after a random gap and, once it is taken, records
  // the result it owes. Valid is left high so that a following beat can go
  // out back to back without a second assignment in the same step.
  task automatic send_pixel(input pixel_t value, input logic tail,
                            input row_check_e check, input result_t typed);
    int gap;
    result_t res;
    gap = src_burst ? 0 : pick_gap();
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel_value <= value;
    pix_bus.is_tail     <= tail;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    if (laplace_step(value, tail, res) && check == CheckPredict) begin
      pending_edges.push_back(res);
    end
    if (check == CheckTyped) pending_edges.push_back(typed);
    pixel_beats++;
  endtask

  // One frame at the current geometry followed by its flush. A broken frame
  // stops at a random point short of its final result, within the first
  // BrokenCap beats. Inside the image a flush flag now and then blanks a
  // pixel; in the flush a plain pixel now and then stands in for a tail
  // beat, and both must count as zero.
  task automatic send_frame(input bit broken, input int drain_at);
    int frame_beats, total, i;
    pixel_t value;
    logic tail;
    frame_beats = geo_width * geo_height;
    total = frame_beats + geo_width + 1;
    if (broken) total = $urandom_range(1, (total > BrokenCap) ? BrokenCap : total - 1);
    for (i = 0; i < total; i++) begin
      if (i == drain_at || $urandom_range(0, 59) == 0) drain_results();
      case ($urandom_range(0, 5))
        0: value = '0;
        1: value = '1;
        default: value = pixel_t'($urandom);
      endcase
      if (i < frame_beats) tail = ($urandom_range(0, 19) == 0);
      else tail = ($urandom_range(0, 7) != 0);
      send_pixel(value, tail, CheckPredict, '0);
    end
  endtask

  // Result sink: checks every accepted beat against the oldest owed result
  // and shapes ready. A hold-off request from the stimulus keeps ready low
  // for a long, fixed stretch so that the output queue fills and the block
  // has to push back on its pixel input.
  initial begin : result_sink
    int hold_left;
    int stall_left;
    result_t want;
    hold_left  = 0;
    stall_left = 0;
    edge_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (edge_bus.valid && edge_bus.ready) begin
        if (pending_edges.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing owed", edge_bus.edge_value));
        end else begin
          want = pending_edges.pop_front();
          if (edge_bus.edge_value !== want.edge_value) begin
            report_mismatch($sformatf("edge_value %0d, predicted %0d",
                                      edge_bus.edge_value, want.edge_value));
          end
          if (edge_bus.frame_last !== want.frame_last) begin
            report_mismatch($sformatf("frame_last %b, predicted %b",
                                      edge_bus.frame_last, want.frame_last));
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        edge_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        edge_bus.ready <= 1'b0;
      end else if (!sink_eager && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        edge_bus.ready <= (stall_left == 0);
      end else begin
        edge_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, the directed rows, then random frames.
  initial begin : stimulus
    int i;
    int phase;
    int beats_at_start;
    int random_beats;
    bit must_cfg;
    bit broken;
    stim_row_t row;

    rst_ni              <= 1'b0;
    pix_bus.valid       <= 1'b0;
    pix_bus.pixel_value <= '0;
    pix_bus.is_tail     <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= RegImageWidth;
    cfg_bus.data        <= '0;

    // Predictor reset state matches the block's: 1024 x 1024, empty window.
    geo_width  = MaxWidth;
    geo_height = MaxHeight;
    for (i = 0; i < MaxWidth; i++) begin
      top_line[i] = '0;
      mid_line[i] = '0;
    end
    restart_window();

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirCount; i++) begin
      row = DirectedRows[i];
      if (row.kind == RowReg) begin
        write_reg(row.reg_index, row.reg_data);
      end else begin
        send_pixel(row.value, row.tail, row.check,
                   result_t'({row.edge_value, row.frame_last}));
      end
    end

    // Random part. Most phases are complete frames with random content, some
    // at a fresh geometry; a few are cut short and force a new geometry,
    // which restarts the frame position. One phase writes out-of-range
    // dimensions, which act as the maximum; another runs a tall frame one
    // pixel wide.
    phase = 0;
    random_beats = 0;
    must_cfg = 1'b1;
    while (random_beats < RandomBeats) begin
      beats_at_start = pixel_beats;
      src_burst  = ($urandom_range(0, 3) == 0);
      sink_eager = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        // Width and height above the maximum act as 1024; the frame is cut
        // short, so the next phase writes a fresh geometry.
        write_reg(RegImageWidth, dim_t'(2047));
        write_reg(RegImageHeight, dim_t'(2047));
        send_frame(1'b1, -1);
        must_cfg = 1'b1;
      end else if (phase == 8) begin
        // Tall frame, one pixel wide; the sender also pauses midway until
        // every owed result has come back.
        write_reg(RegImageWidth, dim_t'(1));
        write_reg(RegImageHeight, dim_t'(300));
        send_frame(1'b0, 150);
        must_cfg = 1'b1;
      end else begin
        if (phase == 1) begin
          // Back pressure: the sink holds off for a long stretch while
          // pixels keep streaming with no gaps.
          write_reg(RegImageWidth, dim_t'(30));
          write_reg(RegImageHeight, dim_t'(4));
          src_burst    = 1'b1;
          sink_eager   = 1'b1;
          hold_request = 1'b1;
        end else if (must_cfg || $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 5) == 0) begin
            write_reg($urandom_range(0, 1) ? RegSpare2 : RegSpare3, dim_t'($urandom));
          end
          write_reg(RegImageWidth, pick_dim(16));
          write_reg(RegImageHeight, pick_dim(6));
        end
        broken = (phase != 1) && ($urandom_range(0, 7) == 0);
        send_frame(broken, -1);
        must_cfg = broken;
      end
      random_beats += pixel_beats - beats_at_start;
      phase++;
    end

    // Wait out every owed result, then let the pipeline settle to catch strays.
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run of about a thousand beats,
  // each with the longest gap on both sides.
  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lap_pkg.sv
rtl/lap_if.sv
rtl/lap_ram.sv
rtl/laplacian_3x3_filter_core.sv
tb/tb_laplacian_3x3_filter_core.sv
